>>> hdl/acal_pkg.sv
// shared types and constants for the accelerometer offset calibrator
// no dependencies; imported by acal_core, accel_offset_calibrator and the testbench
`default_nettype none

package acal_pkg;

  localparam int AXES     = 3;
  localparam int DATA_W   = 16;
  localparam int SCALED_W = 12;
  localparam int ONEG_W   = 11;
  localparam int CFG_IDX_W = 3;
  localparam int SCALE_SH = 4;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_USE_STORED = 3'd0,
    REG_STORED_X   = 3'd1,
    REG_STORED_Y   = 3'd2,
    REG_STORED_Z   = 3'd3,
    REG_ONE_G      = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    ACT_SAMPLE  = 1'b0,
    ACT_RESTART = 1'b1
  } action_t;

  typedef struct packed {
    logic                         use_stored;
    logic [AXES-1:0][DATA_W-1:0]  stored_offset;
    logic [ONEG_W-1:0]            one_g;
  } cfg_t;

  typedef struct packed {
    action_t                      action;
    logic [AXES-1:0][DATA_W-1:0]  raw;
  } item_t;

  typedef struct packed {
    logic [AXES-1:0][DATA_W-1:0]  offset;
    logic                         calibrated;
    logic [AXES-1:0][DATA_W-1:0]  out;
  } res_t;

endpackage

`default_nettype wire

>>> hdl/acal_div.sv
// signed division by a fixed constant, truncating toward zero
// reciprocal multiply on the magnitude, exact for every input of the given width
// self-contained, no package import
`default_nettype none

module acal_div #(
  parameter int WIDTH   = 19,
  parameter int DIVISOR = 99
) (
  input  logic signed [WIDTH-1:0] num,
  output logic signed [WIDTH-1:0] quo
);

  localparam int SH = WIDTH + $clog2(DIVISOR);
  localparam int MW = WIDTH + 1;
  localparam int PW = SH + WIDTH;
  localparam logic [63:0] MULT64 = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [MW-1:0] MULT = MW'(MULT64);

  logic             neg;
  logic [WIDTH-1:0] mag;
  logic [PW-1:0]    prod;
  logic [WIDTH-1:0] qmag;

  always_comb begin
    neg  = num[WIDTH-1];
    mag  = neg ? WIDTH'(-num) : WIDTH'(num);
    prod = PW'(mag) * PW'(MULT);
    qmag = prod[SH +: WIDTH];
    quo  = neg ? -$signed(qmag) : $signed(qmag);
  end

endmodule

`default_nettype wire

>>> hdl/acal_core.sv
// per-item step logic and calibration state (countdown, per-axis sums/offsets)
// depends on acal_pkg and acal_div
`default_nettype none

module acal_core #(
  parameter int CALIB_SAMPLES = 100
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  acal_pkg::item_t item,
  input  acal_pkg::cfg_t  cfg,
  output acal_pkg::res_t  res
);
  import acal_pkg::*;

  localparam int CW    = $clog2(CALIB_SAMPLES + 1);
  localparam int SUM_W = (12 + $clog2(CALIB_SAMPLES) > 17) ? 12 + $clog2(CALIB_SAMPLES) : 17;

  function automatic logic [DATA_W-1:0] sat16(input logic signed [31:0] v);
    if (v > 32'sd32767) begin
      return 16'h7fff;
    end else if (v < -32'sd32768) begin
      return 16'h8000;
    end
    return v[DATA_W-1:0];
  endfunction

  logic [CW-1:0]           left;
  logic [CW-1:0]           left_next;
  logic signed [SUM_W-1:0] sum      [AXES];
  logic signed [SUM_W-1:0] sum_next [AXES];
  logic signed [SUM_W-1:0] quo      [AXES];
  logic signed [SCALED_W-1:0] scaled [AXES];
  logic signed [SUM_W:0]   diff     [AXES];

  for (genvar a = 0; a < AXES; a++) begin : g_div
    acal_div #(.WIDTH(SUM_W), .DIVISOR(CALIB_SAMPLES - 1)) u_div (
      .num (sum[a]),
      .quo (quo[a])
    );
  end

  always_comb begin
    logic signed [DATA_W-1:0] w;
    left_next = left;
    res       = '0;
    for (int a = 0; a < AXES; a++) begin
      w = $signed(item.raw[a]);
      // divide by 16 toward zero: bias negatives before the shift
      scaled[a] = SCALED_W'((w + (w[DATA_W-1] ? 16'sd15 : 16'sd0)) >>> SCALE_SH);
      sum_next[a] = sum[a];
      diff[a] = (SUM_W+1)'(scaled[a]) - (SUM_W+1)'(sum[a]);
    end
    if (item.action == ACT_RESTART) begin
      if (cfg.use_stored) begin
        left_next = '0;
        for (int a = 0; a < AXES; a++) begin
          sum_next[a] = SUM_W'($signed(cfg.stored_offset[a]));
        end
      end else begin
        left_next = CW'(CALIB_SAMPLES);
        for (int a = 0; a < AXES; a++) begin
          sum_next[a] = '0;
        end
      end
    end else if (left != '0) begin
      if (left == CW'(1)) begin
        // last calibration sample: mean becomes the offset, minus one g on z
        for (int a = 0; a < AXES; a++) begin
          sum_next[a] = quo[a];
        end
        sum_next[AXES-1] = quo[AXES-1] - $signed(SUM_W'(cfg.one_g));
      end else begin
        for (int a = 0; a < AXES; a++) begin
          sum_next[a] = sum[a] + SUM_W'(scaled[a]);
        end
      end
      left_next = left - CW'(1);
      for (int a = 0; a < AXES; a++) begin
        res.out[a] = DATA_W'(scaled[a]);
      end
    end else begin
      for (int a = 0; a < AXES; a++) begin
        res.out[a] = sat16(32'(diff[a]));
      end
    end
    res.calibrated = (left_next == '0);
    for (int a = 0; a < AXES; a++) begin
      res.offset[a] = res.calibrated ? sat16(32'(sum_next[a])) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      for (int a = 0; a < AXES; a++) begin
        sum[a] <= '0;
      end
    end else if (adv) begin
      left <= left_next;
      for (int a = 0; a < AXES; a++) begin
        sum[a] <= sum_next[a];
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/accel_offset_calibrator.sv
// top level of the accelerometer offset calibrator: stream ports, input and
// result registers, configuration registers; depends on acal_pkg and acal_core
`default_nettype none

// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tuser: action; tdata: raw_x, raw_y, raw_z
// m_*       out  m_tvalid/m_tready  tuser: calibrated; tdata: out_x..z, offset_x..z
// cfg_*     in   cfg_we             cfg_index, cfg_data (no read-back)
//
// one request per cycle sustained while the master side does not stall; a request
// accepted on the slave side is offered on the master side after it has passed
// the input register, then the result register
// the step logic between the two registers is one pass: scale, accumulate or
// divide by CALIB_SAMPLES-1 through a constant reciprocal multiply, subtract
// and saturate
// synchronous reset clears the countdown, sums, handshake state and cfg registers
// (one_g resets to 256); the block then passes samples through uncorrected
// a stalled result register holds its request; the input register keeps
// accepting as long as the result register can move on the same edge

module accel_offset_calibrator #(
  parameter int CALIB_SAMPLES = 100
) (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // raw_x [15:0], raw_y [31:16], raw_z [47:32]
  input  logic        s_tuser,   // action [0]
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // out_x, out_y, out_z, offset_x, offset_y, offset_z
  output logic        m_tuser,   // calibrated [0]
  // configuration
  input  logic        cfg_we,
  input  logic [acal_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import acal_pkg::*;

  logic  in_valid;
  item_t in_item;
  logic  adv;
  cfg_t  cfg;
  res_t  res;
  res_t  res_q;

  // item moves from the input register into the result register
  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= {action_t'(s_tuser), s_tdata};
    end
  end

  acal_core #(.CALIB_SAMPLES(CALIB_SAMPLES)) u_core (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign m_tdata = {res_q.offset, res_q.out};
  assign m_tuser = res_q.calibrated;

  // configuration registers; indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.use_stored    <= 1'b0;
      cfg.stored_offset <= '0;
      cfg.one_g         <= ONEG_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_USE_STORED: cfg.use_stored       <= cfg_data[0];
        REG_STORED_X:   cfg.stored_offset[0] <= cfg_data;
        REG_STORED_Y:   cfg.stored_offset[1] <= cfg_data;
        REG_STORED_Z:   cfg.stored_offset[2] <= cfg_data;
        REG_ONE_G:      cfg.one_g            <= cfg_data[ONEG_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> verif/tb_accel_offset_calibrator.sv
// self-checking testbench for accel_offset_calibrator: directed and random sample streams
// with its own calibration predictor; depends on acal_pkg and the calibrator rtl
module tb_accel_offset_calibrator;
  import acal_pkg::*;

  localparam int CALIB_SAMPLES  = 100;
  localparam int SCALE_DIV      = 1 << SCALE_SH;
  localparam int RESULT_LATENCY = 2;
  localparam int IDLE_LIMIT     = 4000;
  localparam int RANDOM_ITEMS   = 600;
  localparam logic [ONEG_W-1:0] ONE_G_MAX  = '1;
  localparam logic [DATA_W-1:0] OFFSET_MIN = 16'h8000;
  localparam logic [DATA_W-1:0] OFFSET_MAX = 16'h7FFF;

  // content of the samples fed through a calibration run
  typedef enum int {FILL_RANDOM, FILL_HIGH, FILL_LOW, FILL_BIASED} fill_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // raw_x [15:0], raw_y [31:16], raw_z [47:32]
  logic        s_tuser = ACT_SAMPLE;   // action [0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;        // out_x, out_y, out_z, offset_x, offset_y, offset_z
  logic        m_tuser;        // calibrated [0]
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_USE_STORED;
  logic [15:0] cfg_data = '0;

  // predictor copy of the registers
  logic                     cal_use_stored;
  logic signed [DATA_W-1:0] cal_stored [AXES];
  logic [ONEG_W-1:0]        cal_one_g;
  // predictor copy of the countdown and the per-axis sums / offsets
  int countdown;
  int axis_acc [AXES];

  res_t expected_samples [$];
  int   mismatches   = 0;
  int   items_sent   = 0;
  int   burst_left   = 0;
  int   quiet_cycles = 0;
  string axis_name [AXES] = '{"x", "y", "z"};

  accel_offset_calibrator #(
    .CALIB_SAMPLES(CALIB_SAMPLES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int sat16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // expected result of one request; advances the predictor state
  function automatic res_t corrected_sample(input action_t act,
                                            input logic [AXES-1:0][DATA_W-1:0] raw);
    res_t r;
    int   scaled [AXES];
    r = '0;
    if (act == ACT_RESTART) begin
      // raw fields are don't-care on a restart, the out fields stay zero
      for (int i = 0; i < AXES; i++) axis_acc[i] = cal_use_stored ? int'(cal_stored[i]) : 0;
      countdown = cal_use_stored ? 0 : CALIB_SAMPLES;
    end else begin
      // signed read of the raw word, divide truncates toward zero
      for (int i = 0; i < AXES; i++) scaled[i] = int'($signed(raw[i])) / SCALE_DIV;
      if (countdown > 0) begin
        if (countdown == 1) begin
          // last sample of the run is not summed: it closes the average
          for (int i = 0; i < AXES; i++) axis_acc[i] = axis_acc[i] / (CALIB_SAMPLES - 1);
          axis_acc[AXES-1] -= int'(cal_one_g);
        end else begin
          for (int i = 0; i < AXES; i++) axis_acc[i] += scaled[i];
        end
        countdown--;
        for (int i = 0; i < AXES; i++) r.out[i] = DATA_W'(scaled[i]);
      end else begin
        for (int i = 0; i < AXES; i++) r.out[i] = DATA_W'(sat16(scaled[i] - axis_acc[i]));
      end
    end
    r.calibrated = (countdown == 0);
    // offsets read as zero while the countdown runs
    for (int i = 0; i < AXES; i++)
      r.offset[i] = (countdown == 0) ? DATA_W'(sat16(axis_acc[i])) : '0;
    return r;
  endfunction

  // one request on the slave side, bursts broken by random gaps
  task automatic send_request(input action_t act, input logic [AXES-1:0][DATA_W-1:0] raw);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      // a third of the bursts follow on back to back
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= raw;
    s_tuser  <= act;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    items_sent++;
    expected_samples.push_back(corrected_sample(act, raw));
  endtask

  // sender holds off until every result is back and the pipeline is empty
  task automatic drain_pipeline();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    case (index)
      REG_USE_STORED: cal_use_stored = value[0];
      REG_STORED_X:   cal_stored[0]  = value;
      REG_STORED_Y:   cal_stored[1]  = value;
      REG_STORED_Z:   cal_stored[2]  = value;
      REG_ONE_G:      cal_one_g      = value[ONEG_W-1:0];
      default: ;   // unmapped index, write has no effect
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] sample_word(input fill_t fill,
                                                     input logic [DATA_W-1:0] bias);
    case (fill)
      FILL_HIGH:   return OFFSET_MAX - DATA_W'($urandom_range(0, 15));
      FILL_LOW:    return OFFSET_MIN + DATA_W'($urandom_range(0, 15));
      FILL_BIASED: return bias + DATA_W'($urandom_range(0, 255));
      default:     return DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [AXES-1:0][DATA_W-1:0] random_raw(input fill_t fill,
                                                             input logic [DATA_W-1:0] bias);
    logic [AXES-1:0][DATA_W-1:0] raw;
    for (int i = 0; i < AXES; i++) raw[i] = sample_word(fill, bias);
    return raw;
  endfunction

  function automatic logic [DATA_W-1:0] pick_offset();
    case ($urandom_range(0, 3))
      0:       return OFFSET_MIN;
      1:       return OFFSET_MAX;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  // out of reset: zero offsets, samples pass straight through, scaling edges
  task automatic test_passthrough_after_reset();
    send_request(ACT_SAMPLE, {16'h7FFF, 16'hFFFF, 16'h0000});
    send_request(ACT_SAMPLE, {16'hFFF1, 16'h000F, 16'h8000});
    send_request(ACT_SAMPLE, {16'h8001, 16'h0010, 16'hFFF0});
    send_request(ACT_SAMPLE, {16'h5555, 16'h800F, 16'h7FF0});
  endtask

  // stored offsets at the extremes drive the correction into saturation
  task automatic test_stored_offsets();
    drain_pipeline();
    write_reg(REG_USE_STORED, {15'($urandom), 1'b1});
    write_reg(REG_STORED_X, OFFSET_MIN);
    write_reg(REG_STORED_Y, OFFSET_MAX);
    write_reg(REG_STORED_Z, 16'h0123);
    write_reg(REG_ONE_G, {5'($urandom), ONE_G_MAX});
    // indexes past the register list must be ignored
    for (int i = int'(REG_ONE_G) + 1; i < (1 << CFG_IDX_W); i++)
      write_reg(CFG_IDX_W'(i), 16'($urandom));
    send_request(ACT_RESTART, random_raw(FILL_RANDOM, '0));
    send_request(ACT_SAMPLE, {16'hA5A5, 16'h8000, 16'h7FFF});
    send_request(ACT_SAMPLE, {16'h0000, 16'h7FFF, 16'h8000});
  endtask

  // restart while a countdown is running, both into a new run and into stored
  task automatic test_restart_mid_calibration();
    drain_pipeline();
    write_reg(REG_USE_STORED, 16'h0000);
    send_request(ACT_RESTART, random_raw(FILL_RANDOM, '0));
    send_request(ACT_SAMPLE, random_raw(FILL_HIGH, '0));
    send_request(ACT_SAMPLE, random_raw(FILL_LOW, '0));
    send_request(ACT_RESTART, random_raw(FILL_RANDOM, '0));
    send_request(ACT_SAMPLE, random_raw(FILL_RANDOM, '0));
    drain_pipeline();
    write_reg(REG_USE_STORED, 16'h0001);
    send_request(ACT_RESTART, random_raw(FILL_RANDOM, '0));
    send_request(ACT_SAMPLE, random_raw(FILL_RANDOM, '0));
  endtask

  // mostly complete calibration runs with random content, some noise in between
  task automatic test_random_runs();
    int          target;
    int          phase;
    int          tail;
    fill_t       fill;
    logic [15:0] bias;
    target = items_sent + RANDOM_ITEMS;
    phase  = 0;
    while (items_sent < target) begin
      drain_pipeline();
      write_reg(REG_USE_STORED, {15'($urandom), 1'($urandom_range(0, 3) == 0)});
      write_reg(REG_STORED_X, pick_offset());
      write_reg(REG_STORED_Y, pick_offset());
      write_reg(REG_STORED_Z, pick_offset());
      // one_g at both ends in the first two phases, random after that
      case (phase)
        0:       write_reg(REG_ONE_G, {5'($urandom), ONEG_W'(0)});
        1:       write_reg(REG_ONE_G, {5'($urandom), ONE_G_MAX});
        default: write_reg(REG_ONE_G, 16'($urandom));
      endcase
      fill = fill_t'($urandom_range(0, 3));
      bias = 16'($urandom);
      if ($urandom_range(0, 3) != 0) begin
        send_request(ACT_RESTART, random_raw(FILL_RANDOM, '0));
        if (!cal_use_stored)
          repeat (CALIB_SAMPLES) send_request(ACT_SAMPLE, random_raw(fill, bias));
        tail = $urandom_range(5, 30);
        repeat (tail) send_request(ACT_SAMPLE, random_raw(FILL_RANDOM, '0));
      end else begin
        // noise: restarts scattered among samples, runs often cut short
        tail = $urandom_range(5, 25);
        repeat (tail)
          send_request(($urandom_range(0, 7) == 0) ? ACT_RESTART : ACT_SAMPLE,
                       random_raw(FILL_RANDOM, '0));
      end
      phase++;
    end
  endtask

  // result side stalls on patterns that change at random intervals
  always @(posedge clk) begin : result_stalls
    int pattern;
    int pattern_left;
    int tick;
    if (rst) begin
      m_tready     <= 1'b0;
      pattern      = 0;
      pattern_left = 0;
      tick         = 0;
    end else begin
      if (pattern_left == 0) begin
        pattern      = $urandom_range(0, 3);
        pattern_left = $urandom_range(16, 96);
      end
      pattern_left--;
      tick++;
      case (pattern)
        0:       m_tready <= 1'b1;
        1:       m_tready <= 1'($urandom_range(0, 1));
        2:       m_tready <= (tick % 3) != 0;
        default: m_tready <= ($urandom_range(0, 9) == 0);   // long stalls
      endcase
    end
  end

  task automatic compare_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    res_t got;
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[95:48], m_tuser, m_tdata[47:0]};
      if (expected_samples.size() == 0) begin
        $error("result with no request outstanding: tdata %h tuser %b", m_tdata, m_tuser);
        mismatches++;
      end else begin
        want = expected_samples.pop_front();
        for (int i = 0; i < AXES; i++) compare_field({"out_", axis_name[i]}, want.out[i], got.out[i]);
        compare_field("calibrated", 16'(want.calibrated), 16'(got.calibrated));
        for (int i = 0; i < AXES; i++)
          compare_field({"offset_", axis_name[i]}, want.offset[i], got.offset[i]);
      end
    end
  end

  // watchdog on cycles where neither side moves a request
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $error("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // predictor starts from the reset state of the block
    cal_use_stored = 1'b0;
    cal_one_g      = ONEG_W'(256);
    countdown      = 0;
    for (int i = 0; i < AXES; i++) begin
      cal_stored[i] = '0;
      axis_acc[i]   = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_passthrough_after_reset();
    test_stored_offsets();
    test_restart_mid_calibration();
    test_random_runs();

    drain_pipeline();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/acal_pkg.sv
hdl/acal_div.sv
hdl/acal_core.sv
hdl/accel_offset_calibrator.sv
verif/tb_accel_offset_calibrator.sv
